// File: sv/dtab_pkg.sv
// Shared types and constants for the depth test and alpha blend output stage.
`timescale 1ns / 1ps
package dtab_pkg;
  localparam logic signed [31:0] FAR_DEPTH = 32'sh7fffffff;
  localparam int ONE_Q12 = 4096;
  localparam int CAP_MAX = 16;

  localparam logic [0:0] REG_DEPTH_TEST = 1'b0;
  localparam logic [0:0] REG_BLEND      = 1'b1;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } stage_t;

  // clamp a Q4.12 value to 0..1, then (c*255)>>12
  function automatic logic [7:0] to_byte(input logic signed [15:0] c);
    logic [12:0] cl;
    logic [20:0] p;
    begin
      if (c < 0) cl = '0;
      else if (c > 16'sd4096) cl = 13'd4096;
      else cl = c[12:0];
      p = ({8'd0, cl} << 8) - {8'd0, cl};
      to_byte = p[19:12];
    end
  endfunction

  // (s*a + d*(255-a))>>8, low byte
  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [16:0] t;
    begin
      t = 17'(s) * 17'(a) + 17'(d) * 17'(8'd255 - a);
      mix = t[15:8];
    end
  endfunction
endpackage

// File: sv/depth_test_alpha_blend_rop_unit.sv
// Top level: depth test, colour conversion, alpha blend and frame store writes.
`timescale 1ns / 1ps
// Channel | dir | tdata (low bit up)                                    | tuser    | tlast
// in_     | in  | x[7:0] y[15:8] covered[16] depth[48:17] r[64:49]       | -        | block_end
//         |     | g[80:65] b[96:81] a[112:97], zero to 120 bits          |          |
// out_    | out | out_x[7:0] out_y[15:8] color_word[39:16]               | -        | last_write
// cfg_    | in  | index 0 depth_test_enable, 1 blend_enable               | -        | -
//
// After reset a clearing pass writes every store entry (FRAME_WIDTH*FRAME_HEIGHT,
// 65536 by default), one a cycle; no beat is taken meanwhile. Each pixel passes
// through accept, depth read and compare/write, the depth memory read being
// registered; no new pixel is accepted before its compare/write. A block end then
// drains the stage, each written pixel going through colour read, blend and write,
// and output beat, then a closing step; the drain stalls while out_tready is low.
// Reset is synchronous, active low; stalls on out_ hold the drain in place.
module depth_test_alpha_blend_rop_unit #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int BLOCK_PIXELS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,  // pixel_x, pixel_y, covered, depth, red, green, blue, alpha
  input  logic         in_tlast,  // block_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata, // out_x, out_y, color_word
  output logic         out_tlast, // last_write
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [0:0]   cfg_wdata
);
  localparam int STORE = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(STORE);
  localparam int CAP   = (BLOCK_PIXELS < dtab_pkg::CAP_MAX) ? BLOCK_PIXELS : dtab_pkg::CAP_MAX;
  localparam int CW    = $clog2(CAP + 1);
  localparam int IW    = (CAP > 1) ? $clog2(CAP) : 1;

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_CHK = 3'd3,
                         S_DRD = 3'd4, S_DWR = 3'd5, S_OUT = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic       dte_r, ble_r;
  logic [AW-1:0] clr_r;

  // captured pixel
  logic [7:0] px_r, py_r;
  logic       cov_r, last_r;
  logic signed [31:0] z_r;
  logic signed [15:0] rr_r, gg_r, bb_r, aa_r;

  dtab_pkg::stage_t stage_r [CAP];
  logic [CW-1:0] cnt_r;
  logic          trans_r, blend_r;
  logic [CW-1:0] di_r;
  logic [39:0]   od_r;
  logic          ol_r;

  function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y);
    addr_of = AW'(32'(y) * FRAME_WIDTH + 32'(x));
  endfunction

  logic in_frame;
  assign in_frame = (32'(px_r) < FRAME_WIDTH) && (32'(py_r) < FRAME_HEIGHT);

  dtab_pkg::stage_t cur;
  assign cur = stage_r[di_r[IW-1:0]];

  // depth and colour memories
  logic d_we; logic [AW-1:0] d_wa, d_ra, pa; logic [31:0] d_wd, d_rd;
  logic c_we; logic [AW-1:0] c_wa, c_ra;  logic [23:0] c_wd, c_rd;
  assign pa = addr_of(px_r, py_r);

  dtab_ram #(.WIDTH(32), .DEPTH(STORE)) u_depth (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  dtab_ram #(.WIDTH(24), .DEPTH(STORE)) u_colour (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

  logic pass;
  assign pass = cov_r && in_frame && (!dte_r || (z_r < $signed(d_rd)));

  logic [23:0] word;
  always_comb begin
    if (blend_r)
      word = {dtab_pkg::mix(cur.r, c_rd[23:16], cur.a),
              dtab_pkg::mix(cur.g, c_rd[15:8],  cur.a),
              dtab_pkg::mix(cur.b, c_rd[7:0],   cur.a)};
    else
      word = {cur.r, cur.g, cur.b};
  end

  always_comb begin
    d_we = 1'b0; d_wa = pa; d_wd = z_r; d_ra = pa;
    c_we = 1'b0; c_wa = addr_of(cur.x, cur.y); c_wd = word; c_ra = addr_of(cur.x, cur.y);
    if (st_r == S_CLR) begin
      d_we = 1'b1; d_wa = clr_r; d_wd = dtab_pkg::FAR_DEPTH;
      c_we = 1'b1; c_wa = clr_r; c_wd = '0;
    end else if (st_r == S_CHK) begin
      d_we = pass && dte_r;
    end else if (st_r == S_DWR) begin
      c_we = 1'b1;
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (clr_r == AW'(STORE - 1)) st_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) st_nxt = S_RD;
      S_RD:   st_nxt = S_CHK;
      S_CHK:  st_nxt = last_r ? S_DRD : S_IDLE;
      S_DRD:  st_nxt = (di_r < cnt_r) ? S_DWR : S_IDLE;
      S_DWR:  st_nxt = S_OUT;
      S_OUT:  if (out_tready) st_nxt = S_DRD;
      default: st_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; dte_r <= 1'b0; ble_r <= 1'b0;
      cnt_r <= '0; trans_r <= 1'b0; di_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dtab_pkg::REG_DEPTH_TEST: dte_r <= cfg_wdata[0];
          dtab_pkg::REG_BLEND:      ble_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (st_r == S_CHK) begin
        if (pass && cnt_r < CW'(CAP)) begin
          cnt_r <= cnt_r + 1'b1;
          if (aa_r < 16'sd4096) trans_r <= 1'b1;
        end
        di_r <= '0;
      end
      if (st_r == S_DRD && di_r >= cnt_r) begin
        cnt_r <= '0; trans_r <= 1'b0;
      end
      if (st_r == S_OUT && out_tready) di_r <= di_r + 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_tvalid) begin
      px_r <= in_tdata[7:0];   py_r <= in_tdata[15:8]; cov_r <= in_tdata[16];
      z_r  <= in_tdata[48:17]; rr_r <= in_tdata[64:49]; gg_r <= in_tdata[80:65];
      bb_r <= in_tdata[96:81]; aa_r <= in_tdata[112:97]; last_r <= in_tlast;
    end
    if (st_r == S_CHK) begin
      if (pass && cnt_r < CW'(CAP)) begin
        stage_r[cnt_r[IW-1:0]] <= '{x: px_r, y: py_r, r: dtab_pkg::to_byte(rr_r),
                                   g: dtab_pkg::to_byte(gg_r), b: dtab_pkg::to_byte(bb_r),
                                   a: dtab_pkg::to_byte(aa_r)};
        blend_r <= ble_r && (trans_r || aa_r < 16'sd4096);
      end else begin
        blend_r <= ble_r && trans_r;
      end
    end
    if (st_r == S_DWR) begin
      od_r <= {word, cur.y, cur.x};
      ol_r <= (di_r + 1'b1 == cnt_r);
    end
  end
endmodule

// File: sv/dtab_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module dtab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: tb/depth_test_alpha_blend_rop_unit_tb.sv
// Testbench for the raster output stage: depth test, colour conversion, blend and write-out.
`timescale 1ns / 1ps
module depth_test_alpha_blend_rop_unit_tb;

  // one shaded pixel as it enters the block
  typedef struct {
    logic [7:0]         px;
    logic [7:0]         py;
    logic               cov;
    logic signed [31:0] z;
    logic signed [15:0] r;
    logic signed [15:0] g;
    logic signed [15:0] b;
    logic signed [15:0] a;
    logic               blk_end;
  } pixel_t;

  // one written pixel as it leaves the block
  typedef struct {
    logic [7:0]  wx;
    logic [7:0]  wy;
    logic [23:0] colour;
    logic        last;
  } write_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;  // x, y, covered, depth, r, g, b, a (low bit up)
  logic         in_tlast = 1'b0; // block_end
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;       // out_x, out_y, color_word (low bit up)
  logic         out_tlast;       // last_write
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = dtab_pkg::REG_DEPTH_TEST;
  logic [0:0]   cfg_wdata = 1'b0;

  depth_test_alpha_blend_rop_unit dut (.*);

  always #5 clk = ~clk;

  // predictor state: shadow frame stores, stage and registers
  logic signed [31:0] z_buf [65536];
  logic [23:0]        c_buf [65536];
  dtab_pkg::stage_t   staged [16];
  int                 staged_n;
  logic               translucent;
  logic               zt_on;
  logic               blend_on;

  pixel_t pending_px[$];
  write_t expected_writes[$];

  int  mismatches = 0;
  int  writes_seen = 0;
  int  beats_sent = 0;
  int  cycles = 0;
  bit  stim_done = 1'b0;
  bit  hold_sender = 1'b0;   // sender paused by the stimulus thread
  int  hold_off = 0;         // receiver long stall, cycles left
  bit  kick_hold_off = 1'b0;

  function automatic logic [7:0] q12_to_byte(input logic signed [15:0] c);
    int v;
    v = c;
    if (v < 0) v = 0;
    if (v > 4096) v = 4096;
    return 8'((v * 255) >>> 12);
  endfunction

  function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
    int t;
    t = (int'(s) * int'(a) + int'(d) * (255 - int'(a))) >> 8;
    return 8'(t);
  endfunction

  // apply one accepted pixel to the shadow state, queue any writes it causes
  task automatic predict_pixel(input pixel_t p);
    int     addr;
    bit     keep;
    bit     do_blend;
    dtab_pkg::stage_t s;
    logic [7:0] cr, cg, cb;
    logic [23:0] d;
    addr = {p.py, p.px};
    if (p.cov) begin
      keep = 1'b1;
      if (zt_on) begin
        if (p.z < z_buf[addr]) z_buf[addr] = p.z;
        else keep = 1'b0;
      end
      if (keep && staged_n < 16) begin
        s.x = p.px; s.y = p.py;
        s.r = q12_to_byte(p.r); s.g = q12_to_byte(p.g);
        s.b = q12_to_byte(p.b); s.a = q12_to_byte(p.a);
        staged[staged_n] = s;
        if (p.a < 16'sd4096) translucent = 1'b1;
        staged_n++;
      end
    end
    if (p.blk_end) begin
      do_blend = blend_on && translucent;
      for (int i = 0; i < staged_n; i++) begin
        s = staged[i];
        addr = {s.y, s.x};
        cr = s.r; cg = s.g; cb = s.b;
        if (do_blend) begin
          d = c_buf[addr];
          cr = blend_ch(cr, d[23:16], s.a);
          cg = blend_ch(cg, d[15:8], s.a);
          cb = blend_ch(cb, d[7:0], s.a);
        end
        c_buf[addr] = {cr, cg, cb};
        expected_writes.push_back('{s.x, s.y, {cr, cg, cb}, i == staged_n - 1});
      end
      staged_n = 0;
      translucent = 1'b0;
    end
  endtask

  // driver: bursts of offered beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_pixel(pending_px.pop_front());
        beats_sent <= beats_sent + 1;
      end
      // decide what to offer for the next edge (one assignment per signal)
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (hold_sender || pending_px.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          pixel_t n;
          n = pending_px[0];
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, n.a, n.b, n.g, n.r, n.z, n.cov, n.py, n.px};
          in_tlast <= n.blk_end;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern plus the long hold-off
  always @(posedge clk) begin
    if (kick_hold_off && hold_off == 0) hold_off <= 400;
    else if (hold_off > 0) hold_off <= hold_off - 1;
    if (!rst_n || hold_off > 1) out_tready <= 1'b0;
    else if (cycles[9:8] == 2'b01) out_tready <= 1'b1;       // stall-free stretch
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // monitor: compare each written pixel against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      write_t w;
      writes_seen <= writes_seen + 1;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected write %h last %b", out_tdata, out_tlast);
      end else begin
        w = expected_writes.pop_front();
        if (out_tdata[7:0] !== w.wx || out_tdata[15:8] !== w.wy ||
            out_tdata[39:16] !== w.colour || out_tlast !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("write mismatch: exp x%0d y%0d c%h l%b got x%0d y%0d c%h l%b",
                     w.wx, w.wy, w.colour, w.last, out_tdata[7:0], out_tdata[15:8],
                     out_tdata[39:16], out_tlast);
        end
      end
    end
  end

  // watchdog: clear pass plus every beat at its slowest, several times over
  always @(posedge clk) begin
    if (cycles > 1500000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_colour();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd4096;
      3: return 16'(16'sd4096 + $urandom_range(0, 1) * 2 - 1);
      4: return 16'($urandom);
      default: return 16'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic pixel_t rand_pixel(input bit in_tile, input bit last);
    pixel_t p;
    p.px = in_tile ? 8'($urandom_range(0, 3)) : 8'($urandom);
    p.py = in_tile ? 8'($urandom_range(0, 3)) : 8'($urandom);
    p.cov = ($urandom_range(0, 5) != 0);
    p.z = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4000));
    if ($urandom_range(0, 15) == 0) p.z = 32'sh7fffffff;
    p.r = rand_colour(); p.g = rand_colour(); p.b = rand_colour();
    p.a = ($urandom_range(0, 2) == 0) ? 16'sd4096 : rand_colour();
    p.blk_end = last;
    return p;
  endfunction

  // queue one block of n pixels, the last carrying block_end
  task automatic add_block(input int n, input bit in_tile);
    for (int i = 0; i < n; i++) pending_px.push_back(rand_pixel(in_tile, i == n - 1));
  endtask

  task automatic wait_drained();
    while (pending_px.size() != 0 || in_tvalid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    if (idx == dtab_pkg::REG_DEPTH_TEST) zt_on = val; else blend_on = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    pixel_t p;
    for (int i = 0; i < 65536; i++) begin
      z_buf[i] = dtab_pkg::FAR_DEPTH;
      c_buf[i] = '0;
    end
    staged_n = 0; translucent = 1'b0; zt_on = 1'b0; blend_on = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, depth test off, blend off
    p = '{8'd0, 8'd0, 1'b1, 32'sh80000000, 16'sh8000, 16'sh7fff, 16'sd4096, 16'sd4095, 1'b0};
    pending_px.push_back(p);
    p = '{8'd255, 8'd255, 1'b1, 32'sh7fffffff, 16'sd4097, 16'sd0, 16'sh7fff, 16'sh8000, 1'b0};
    pending_px.push_back(p);
    p = '{8'd170, 8'd85, 1'b0, 32'sh55555555, 16'sh5555, 16'shaaaa, 16'sd1, 16'sd1, 1'b0};
    pending_px.push_back(p);  // uncovered: ignored
    p = '{8'd0, 8'd0, 1'b1, 32'sd0, 16'sd2048, 16'sd2048, 16'sd2048, 16'sd4096, 1'b1};
    pending_px.push_back(p);  // repeated position in the same block
    p = '{8'd9, 8'd9, 1'b0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};
    pending_px.push_back(p);  // block end with nothing staged
    wait_drained();

    // depth test and blend on: strict compare, equal depth dropped, stage overflow
    write_reg(dtab_pkg::REG_DEPTH_TEST, 1'b1);
    write_reg(dtab_pkg::REG_BLEND, 1'b1);
    p = '{8'd0, 8'd0, 1'b1, 32'sd100, 16'sd4096, 16'sd0, 16'sd1000, 16'sd2048, 1'b0};
    pending_px.push_back(p);
    p.z = 32'sd100; pending_px.push_back(p);       // equal depth fails
    p.z = 32'sd99; p.a = 16'sd4096; pending_px.push_back(p);
    for (int i = 0; i < 16; i++) begin
      p = '{8'(i), 8'd1, 1'b1, 32'sd5, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096, 1'b0};
      pending_px.push_back(p);                     // overflow: last two not staged
    end
    p.px = 8'd200; p.a = 16'sd100; p.blk_end = 1'b1;
    pending_px.push_back(p);                       // beyond stage, translucency not counted
    wait_drained();

    // random phases over every register setting
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(dtab_pkg::REG_DEPTH_TEST, ph[0]);
      write_reg(dtab_pkg::REG_BLEND, ph[1]);
      if (ph == 2) kick_hold_off = 1'b1;
      for (int k = 0; k < 10; k++) begin
        add_block(($urandom_range(0, 7) == 0) ? $urandom_range(17, 20)
                                               : $urandom_range(1, 8),
                  $urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0) pending_px.push_back(rand_pixel(1'b0, 1'b0)); // stray
      end
      if (ph == 2) begin
        repeat (20) @(posedge clk);
        kick_hold_off = 1'b0;
      end
      if (ph == 1) begin
        // sender pauses until every write has come back
        while (pending_px.size() > 20) @(posedge clk);
        hold_sender = 1'b1;
        while (in_tvalid || expected_writes.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    // stray pixels without a block end are flushed by a final empty-ish block
    pending_px.push_back(rand_pixel(1'b1, 1'b1));
    wait_drained();
    stim_done = 1'b1;
    $display("Covered %0d pixel beats and %0d written pixels over all depth/blend settings",
             beats_sent, writes_seen);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d writes outstanding", mismatches,
               expected_writes.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
